[design/psq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psq_pkg
// Shared types, codes and the full-step coil table of the phase sequencer.
// ----------------------------------------------------------------------------
package psq_pkg;

    // Default width of the period accumulator, comparator and tick counter
    localparam int COUNT_BITS_DEF = 16;

    // Event codes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_BYTE   = 2'd1;
    localparam logic [1:0] OP_BUTTON = 2'd2;

    // Serial characters of interest
    localparam logic [7:0] CHAR_CR   = 8'd13;
    localparam logic [7:0] CHAR_ZERO = 8'd48;
    localparam logic [7:0] CHAR_NINE = 8'd57;

    // Coil patterns, in step order
    localparam logic [5:0] COIL_A = 6'h20;
    localparam logic [5:0] COIL_B = 6'h01;
    localparam logic [5:0] COIL_C = 6'h04;
    localparam logic [5:0] COIL_D = 6'h08;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } cmd_t;

    typedef struct packed {
        logic [5:0] coil_pattern;
        logic       step_taken;
        logic       reverse_now;
    } res_t;

    function automatic logic [5:0] coil_lookup(input logic [1:0] idx);
        logic [5:0] pat;
        unique case (idx)
            2'd0:    pat = COIL_A;
            2'd1:    pat = COIL_B;
            2'd2:    pat = COIL_C;
            default: pat = COIL_D;
        endcase
        return pat;
    endfunction

endpackage

[design/psq_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psq_engine
// Sequencer state and its single-pass update for one event.
// ----------------------------------------------------------------------------
module psq_engine #(
    parameter int COUNT_BITS = psq_pkg::COUNT_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  psq_pkg::cmd_t  item,
    output psq_pkg::res_t  result
);

    localparam int PROD_BITS = COUNT_BITS + 4;

    logic [COUNT_BITS-1:0] digit_accum_reg,   digit_accum_next;
    logic [COUNT_BITS-1:0] compare_value_reg, compare_value_next;
    logic [COUNT_BITS-1:0] tick_count_reg,    tick_count_next;
    logic                  timer_on_reg,      timer_on_next;
    logic [1:0]            phase_index_reg,   phase_index_next;
    logic                  spin_reverse_reg,  spin_reverse_next;
    logic [5:0]            drive_pattern_reg, drive_pattern_next;

    logic                  is_digit;
    logic [3:0]            digit_val;
    logic [PROD_BITS-1:0]  accum_wide;
    logic [PROD_BITS-1:0]  accum_sum;
    logic [COUNT_BITS-1:0] accum_sat;
    logic                  stepped;

    assign is_digit   = (item.rx_byte >= psq_pkg::CHAR_ZERO) &&
                        (item.rx_byte <= psq_pkg::CHAR_NINE);
    assign digit_val  = 4'(item.rx_byte - psq_pkg::CHAR_ZERO);
    assign accum_wide = {4'b0000, digit_accum_reg};
    // accum * 10 as (accum << 3) + (accum << 1), plus the new digit
    assign accum_sum  = (accum_wide << 3) + (accum_wide << 1)
                      + {{(PROD_BITS-4){1'b0}}, digit_val};
    assign accum_sat  = (accum_sum[PROD_BITS-1:COUNT_BITS] != 4'b0000) ?
                        {COUNT_BITS{1'b1}} : accum_sum[COUNT_BITS-1:0];

    always_comb
    begin
        digit_accum_next   = digit_accum_reg;
        compare_value_next = compare_value_reg;
        tick_count_next    = tick_count_reg;
        timer_on_next      = timer_on_reg;
        phase_index_next   = phase_index_reg;
        spin_reverse_next  = spin_reverse_reg;
        drive_pattern_next = drive_pattern_reg;
        stepped            = 1'b0;
        unique case (item.operation)
            psq_pkg::OP_TICK:
            begin
                if (timer_on_reg)
                begin
                    if (tick_count_reg == compare_value_reg)
                    begin
                        stepped            = 1'b1;
                        tick_count_next    = '0;
                        drive_pattern_next = psq_pkg::coil_lookup(phase_index_reg);
                        phase_index_next   = spin_reverse_reg ? phase_index_reg - 2'd1
                                                              : phase_index_reg + 2'd1;
                    end
                    else
                    begin
                        tick_count_next = tick_count_reg + COUNT_BITS'(1);
                    end
                end
            end
            psq_pkg::OP_BYTE:
            begin
                if (is_digit)
                begin
                    digit_accum_next = accum_sat;
                end
                else if (item.rx_byte == psq_pkg::CHAR_CR)
                begin
                    // zero period wraps to all ones
                    compare_value_next = digit_accum_reg - COUNT_BITS'(1);
                    tick_count_next    = '0;
                    timer_on_next      = 1'b1;
                    digit_accum_next   = '0;
                end
            end
            psq_pkg::OP_BUTTON:
            begin
                spin_reverse_next = !spin_reverse_reg;
            end
            default:
            begin
                // spare code: no change
            end
        endcase
    end

    assign result.coil_pattern = drive_pattern_next;
    assign result.step_taken   = stepped;
    assign result.reverse_now  = spin_reverse_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_accum_reg   <= '0;
            compare_value_reg <= '0;
            tick_count_reg    <= '0;
            timer_on_reg      <= 1'b0;
            phase_index_reg   <= 2'd0;
            spin_reverse_reg  <= 1'b0;
            drive_pattern_reg <= 6'd0;
        end
        else if (fire)
        begin
            digit_accum_reg   <= digit_accum_next;
            compare_value_reg <= compare_value_next;
            tick_count_reg    <= tick_count_next;
            timer_on_reg      <= timer_on_next;
            phase_index_reg   <= phase_index_next;
            spin_reverse_reg  <= spin_reverse_next;
            drive_pattern_reg <= drive_pattern_next;
        end
    end

`ifndef SYNTHESIS
    // counter restarts at zero and clears on match, so it never passes the comparator
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        tick_count_reg <= compare_value_reg)
        else $error("tick counter beyond comparator");
`endif

endmodule

[design/stepper_phase_sequencer_with_rate_entry_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_with_rate_entry_core
// Full-step stepper sequencer with a serial step-period entry.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd_data) carries one event per
//   transfer: a 1 ms tick, a received serial byte or a button press.
//   res channel (res_valid / res_stall / res_data) returns exactly one result
//   per event, in order: coil pattern held, step flag, direction.
//   Digits build the period in ticks; carriage return arms the timer with
//   period-1 and restarts the counter. Button presses flip direction.
// Path: an event transferred on cmd waits in the command register, is processed
//   as it moves into the result register and is offered on res from then on.
// Throughput: one event per cycle unless res stalls; the whole update is one
//   combinational pass through the engine between command and result registers.
// Stall: when res is stalled with a result waiting, the command register holds
//   its event and cmd_stall rises only if that register is occupied.
// Reset: all sequencer state clears (timer off, forward, pattern 0) and both
//   registers empty.
// ----------------------------------------------------------------------------
module stepper_phase_sequencer_with_rate_entry_core #(
    parameter int COUNT_BITS = psq_pkg::COUNT_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  psq_pkg::cmd_t cmd_data,
    output logic          res_valid,
    input  logic          res_stall,
    output psq_pkg::res_t res_data
);

    logic          cmd_valid_reg, cmd_valid_next;
    psq_pkg::cmd_t cmd_item_reg;
    logic          res_valid_reg, res_valid_next;
    psq_pkg::res_t res_item_reg;

    logic          advance;    // command register moves into the result register
    logic          accept;     // cmd transfer this edge
    psq_pkg::res_t engine_res;

    assign advance   = cmd_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = cmd_valid_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;

    psq_engine #(
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (cmd_item_reg),
        .result (engine_res)
    );

    always_comb
    begin
        priority if (accept)
            cmd_valid_next = 1'b1;
        else if (advance)
            cmd_valid_next = 1'b0;
        else
            cmd_valid_next = cmd_valid_reg;

        priority if (advance)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_item_reg <= cmd_data;
        end
        if (advance)
        begin
            res_item_reg <= engine_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_item_reg;

`ifndef SYNTHESIS
    // a step always drives one of the table patterns
    a_step_has_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.step_taken |-> res_data.coil_pattern != 6'd0)
        else $error("step without coil pattern");

    a_pattern_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $onehot0(res_data.coil_pattern))
        else $error("coil pattern not one-hot");

    // a stalled result keeps the queued command in place
    a_cmd_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid_reg && res_valid && res_stall |=> cmd_valid_reg && $stable(cmd_item_reg))
        else $error("queued command lost under stall");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> cmd_valid_reg && res_valid_reg)
        else $error("stall with free command register");
`endif

endmodule
